// ===== hdl/cwct_pkg.sv =====
// shared definitions for the code write count tracker
// item kind codes, row geometry, default sizes and controller/datapath structs
package cwct_pkg;

	// field widths fixed by the item format
	localparam int KIND_W = 2;
	localparam int ADDR_W = 16;
	localparam int LEN_W  = 13;
	localparam int CNT_W  = 8;

	// item kinds
	localparam logic [KIND_W-1:0] KIND_MARK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	// counter limit after reset
	localparam logic [CNT_W-1:0] LIMIT_RESET = 8'd255;

	// one memory row holds the counters of 32 consecutive bytes
	localparam int ROW_SHIFT = 5;
	localparam int ROW_BYTES = 1 << ROW_SHIFT;

	// default sizes
	localparam int DEF_ADDR_BITS = 16;
	localparam int DEF_PAGE_BITS = 12;
	localparam int DEF_MAX_RANGE = 4096;

	// controller to datapath commands
	typedef struct packed {
		logic load;        // capture a new item
		logic step_read;   // read the next row of the range and advance
		logic mark_write;  // write back the incremented row
		logic check;       // fold the read row into the query result
		logic clr_step;    // write one zero row and advance the clear pointer
		logic out_load;    // move the result into the output register
	} cwct_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic rem_zero;    // no bytes of the range left
		logic page_last;   // clear pointer sits on the last row of its page
		logic sweep_last;  // clear pointer sits on the last row of memory
	} cwct_stat_t;

endpackage

// ===== hdl/cwct_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
module cwct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/cwct_dp.sv =====
// datapath of the code write count tracker: range walker, counter ram,
// row increment and query check, clear pointer, limit register, result register
// depends on cwct_pkg and cwct_ram
module cwct_dp import cwct_pkg::*; #(
	parameter int ADDR_BITS = DEF_ADDR_BITS,
	parameter int PAGE_BITS = DEF_PAGE_BITS,
	parameter int MAX_RANGE = DEF_MAX_RANGE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cwct_cmd_t         cmd,
	output cwct_stat_t        stat,
	input  logic [ADDR_W-1:0] address,
	input  logic [LEN_W-1:0]  length,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata,
	output logic              dynamic
);

	localparam int RW    = ADDR_BITS - ROW_SHIFT;
	localparam int DEPTH = 1 << RW;
	localparam int PG    = (PAGE_BITS < ADDR_BITS) ? PAGE_BITS : ADDR_BITS;
	localparam logic [RW-1:0] PAGE_ROW_MASK = ~RW'((64'd1 << (PG - ROW_SHIFT)) - 64'd1);
	localparam int OW = ROW_SHIFT + 1;
	localparam int HW = ROW_SHIFT + 2;

	logic [ADDR_BITS-1:0]     cur_q;
	logic [LEN_W-1:0]         rem_q;
	logic [RW-1:0]            row_s1;
	logic [ROW_BYTES-1:0]     mask_s1;
	logic                     hit_q;
	logic                     dynamic_q;
	logic [RW-1:0]            clr_row_q;
	logic [CNT_W-1:0]         limit_q;

	logic [LEN_W-1:0]         len_clamp;
	logic [ADDR_BITS-1:0]     addr_in;
	logic [ROW_SHIFT-1:0]     off;
	logic [OW-1:0]            avail;
	logic [OW-1:0]            take;
	logic [HW-1:0]            lo;
	logic [HW-1:0]            hi;
	logic [ROW_BYTES-1:0]     mask;
	logic [ROW_BYTES*CNT_W-1:0] rdata;
	logic [ROW_BYTES*CNT_W-1:0] mod_row;
	logic                     row_hit;
	logic                     ram_we;
	logic                     ram_re;
	logic [RW-1:0]            ram_waddr;
	logic [ROW_BYTES*CNT_W-1:0] ram_wdata;

	// input capture helpers
	assign addr_in   = ADDR_BITS'(address);
	assign len_clamp = (32'(length) > MAX_RANGE) ? LEN_W'(MAX_RANGE) : length;

	// bytes of the range that fall in the current row
	assign off   = cur_q[ROW_SHIFT-1:0];
	assign avail = OW'(ROW_BYTES) - OW'(off);
	assign take  = (rem_q < LEN_W'(avail)) ? OW'(rem_q) : avail;
	assign lo    = HW'(off);
	assign hi    = lo + HW'(take);

	always_comb begin
		for (int j = 0; j < ROW_BYTES; j++) begin
			mask[j] = (HW'(j) >= lo) && (HW'(j) < hi);
		end
	end

	// saturating increment and nonzero check over the row read last cycle
	always_comb begin
		row_hit = 1'b0;
		for (int j = 0; j < ROW_BYTES; j++) begin
			mod_row[j*CNT_W +: CNT_W] = rdata[j*CNT_W +: CNT_W];
			if (mask_s1[j] && (rdata[j*CNT_W +: CNT_W] < limit_q)) begin
				mod_row[j*CNT_W +: CNT_W] = rdata[j*CNT_W +: CNT_W] + 8'd1;
			end
			if (mask_s1[j] && (rdata[j*CNT_W +: CNT_W] != '0)) begin
				row_hit = 1'b1;
			end
		end
	end

	// counter memory ports
	assign ram_re    = cmd.step_read;
	assign ram_we    = cmd.mark_write | cmd.clr_step;
	assign ram_waddr = cmd.mark_write ? row_s1 : clr_row_q;
	assign ram_wdata = cmd.mark_write ? mod_row : '0;

	cwct_ram #(
		.WIDTH (ROW_BYTES * CNT_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (cur_q[ADDR_BITS-1:ROW_SHIFT]),
		.rdata (rdata)
	);

	// range walker, row stage and result registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q <= addr_in;
			rem_q <= len_clamp;
			hit_q <= 1'b0;
		end else begin
			if (cmd.step_read) begin
				cur_q   <= cur_q + ADDR_BITS'(take);
				rem_q   <= rem_q - LEN_W'(take);
				row_s1  <= cur_q[ADDR_BITS-1:ROW_SHIFT];
				mask_s1 <= mask;
			end
			if (cmd.check && row_hit) begin
				hit_q <= 1'b1;
			end
		end
		if (cmd.out_load) begin
			dynamic_q <= hit_q;
		end
	end

	// clear pointer and limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_row_q <= '0;
			limit_q   <= LIMIT_RESET;
		end else begin
			if (cmd.load) begin
				clr_row_q <= addr_in[ADDR_BITS-1:ROW_SHIFT] & PAGE_ROW_MASK;
			end else if (cmd.clr_step) begin
				clr_row_q <= clr_row_q + RW'(1);
			end
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
		end
	end

	assign stat.rem_zero   = (rem_q == '0);
	assign stat.page_last  = ((clr_row_q & ~PAGE_ROW_MASK) == ~PAGE_ROW_MASK);
	assign stat.sweep_last = &clr_row_q;
	assign dynamic         = dynamic_q;

	// a row is never read and written in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("counter ram read and write in the same cycle");

	// a mark write-back always follows the read of its row
	a_mark_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mark_write |-> $past(cmd.step_read))
		else $error("mark write-back without a preceding row read");

	// every row step consumes at least one byte of the range
	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step_read && !cmd.load) |=> (rem_q < $past(rem_q)))
		else $error("range walker did not advance");

endmodule

// ===== hdl/cwct_ctrl.sv =====
// controller of the code write count tracker: reset sweep, per item sequencing,
// input and output handshakes
// depends on cwct_pkg
module cwct_ctrl import cwct_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	output logic              out_valid,
	input  logic              out_ready,
	input  cwct_stat_t        stat,
	output cwct_cmd_t         cmd
);

	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_MARK  = 3'd3;
	localparam logic [2:0] ST_CHECK = 3'd4;
	localparam logic [2:0] ST_CLEAR = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0]        state_q;
	logic [2:0]        state_nx;
	logic [KIND_W-1:0] kind_q;
	logic              out_valid_q;
	logic              accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		unique case (state_q)
			ST_SWEEP: begin
				cmd.clr_step = 1'b1;
				if (stat.sweep_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					case (kind) inside
						KIND_MARK, KIND_QUERY: state_nx = ST_READ;
						KIND_CLEAR:            state_nx = ST_CLEAR;
						default:               state_nx = ST_DONE;
					endcase
				end
			end
			ST_READ: begin
				if (stat.rem_zero) begin
					state_nx = ST_DONE;
				end else begin
					cmd.step_read = 1'b1;
					state_nx = (kind_q == KIND_MARK) ? ST_MARK : ST_CHECK;
				end
			end
			ST_MARK: begin
				cmd.mark_write = 1'b1;
				state_nx = ST_READ;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_nx = ST_READ;
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.page_last) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state, captured kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			kind_q      <= KIND_MARK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				kind_q <= kind;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	// one item at a time: nothing is taken right after a transaction
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("input accepted while an item is in work");

	// a result never overwrites one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before transaction");

	// a waiting result stays valid until its transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("result dropped before transaction");

endmodule

// ===== hdl/code_write_count_tracker.sv =====
// Code write count tracker: one saturating 8-bit write counter per byte of
// guest code memory, kept in a ram of 32-byte rows.
// Input channel (in_valid/in_ready): kind, address, length. Kind mark adds one
// to each counter of the range up to the limit, kind query asks whether any
// counter of the range is nonzero, kind clear zeroes the page of the address.
// Output channel (out_valid/out_ready): one transaction per item; dynamic is
// the query answer and 0 for every other kind.
// Config: cfg_we/cfg_wdata write the counter limit, 255 after reset.
// Operation: one item at a time. Mark and query walk the 32-byte rows that
// the range touches, reading each row and then writing it back (mark) or
// checking it (query); clear writes a zero row for each row of the page and
// an unused kind goes straight to its result. The next item can be taken in
// the cycle after the result is loaded.
// Reset: a sweep zeroes the ram one row per cycle, from the first row to the
// last; in_ready stays low until it ends.
// Stall: the result waits in an output register; the next item is taken and
// worked on meanwhile and holds only its own result until the slot frees.
// depends on cwct_pkg, cwct_ctrl, cwct_dp
module code_write_count_tracker import cwct_pkg::*; #(
	parameter int ADDR_BITS = DEF_ADDR_BITS,
	parameter int PAGE_BITS = DEF_PAGE_BITS,
	parameter int MAX_RANGE = DEF_MAX_RANGE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [KIND_W-1:0] kind,
	input  logic [ADDR_W-1:0] address,
	input  logic [LEN_W-1:0]  length,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              dynamic,
	input  logic              cfg_we,
	input  logic [CNT_W-1:0]  cfg_wdata
);

	cwct_cmd_t  cmd;
	cwct_stat_t stat;

	// sequencing and handshakes
	cwct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// counters and range walking
	cwct_dp #(
		.ADDR_BITS (ADDR_BITS),
		.PAGE_BITS (PAGE_BITS),
		.MAX_RANGE (MAX_RANGE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.address   (address),
		.length    (length),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.dynamic   (dynamic)
	);

endmodule
